### src/rolling_window_structuring_detector_assert.svh
// Assertion macros used by the detector back end
`ifndef ROLLING_WINDOW_STRUCTURING_DETECTOR_ASSERT_SVH
`define ROLLING_WINDOW_STRUCTURING_DETECTOR_ASSERT_SVH

// Condition must never hold outside reset
`define RWSD_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// Same-cycle implication
`define RWSD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rwsd_pkg.sv
// Shared constants, types and helpers of the rolling window detector
package rwsd_pkg;

    localparam int Q_DEPTH    = 64;
    localparam int DAY_W      = 24;
    localparam int AMT_W      = 40;
    localparam int WDAYS_W    = 16;
    localparam int CFG_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_FW       = $clog2(Q_DEPTH + 1);
    localparam int SUM_W      = AMT_W + $clog2(Q_DEPTH);
    localparam int WSUM_W     = 46;
    localparam int WCNT_W     = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_DAYS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

    localparam logic [WDAYS_W-1:0] SPAN_DAYS_RST = WDAYS_W'(3);
    localparam logic [AMT_W-1:0]   THRESHOLD_RST = AMT_W'(1000000);

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [AMT_W-1:0] amount;
        logic             last;
        logic             over;
    } t_cmd;

    typedef struct packed {
        logic              flagged;
        logic [WSUM_W-1:0] flag_sum;
        logic [WCNT_W-1:0] window_count;
        logic [DAY_W-1:0]  flag_start_day;
        logic              truncated;
    } t_result;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    function automatic logic [WSUM_W-1:0] sat_sum(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] hi;
        hi = x >> WSUM_W;
        if ((SUM_W > WSUM_W) && (hi != '0)) begin
            return '1;
        end
        return WSUM_W'(x);
    endfunction

endpackage

### src/rolling_window_structuring_detector.sv
// Top level of the rolling window structuring detector
//
// Input channel (i_valid/o_ready): one transaction per transfer, day plus
// amount in cents, days non-decreasing within an account; i_last_of_account
// marks the final transaction. Output channel (o_valid/i_ready): one result
// per account, given only after its last transaction, in a registered slot.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 window length
// in days, 1 threshold_cents) with no wait; write only while no transaction is in flight.
// Flow: a two-entry command queue feeds the back end, which for each transaction
// first closes the windows that its day ends (or the oldest one, on overflow) and
// then pushes it (queue memory read ahead at the next head).
// Path of the last transaction: the command queue, a close for each window it
// ends, the push, a close for each window still open, then the result load.
// Reset clears all window state and loads a 3 day window, threshold 1000000.
// A stalled receiver holds the result; the back end then waits on the last
// transaction while the front keeps taking one more transfer.
module rolling_window_structuring_detector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rwsd_pkg::DAY_W-1:0]       i_day,
    input  logic [rwsd_pkg::AMT_W-1:0]       i_amount_cents,
    input  logic                             i_last_of_account,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_flagged,
    output logic [rwsd_pkg::WSUM_W-1:0]      o_flag_sum,
    output logic [rwsd_pkg::WCNT_W-1:0]      o_window_count,
    output logic [rwsd_pkg::DAY_W-1:0]       o_flag_start_day,
    output logic                             o_truncated,
    input  logic                             i_cfg_we,
    input  logic [rwsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rwsd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import rwsd_pkg::*;

    logic [WDAYS_W-1:0] r_span_days;
    logic [AMT_W-1:0]   r_threshold;
    logic               cmd_valid, cmd_pop;
    t_cmd               cmd;
    t_result            result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_days <= SPAN_DAYS_RST;
            r_threshold <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SPAN_DAYS: r_span_days <= WDAYS_W'(i_cfg_data);
                CFG_THRESHOLD: r_threshold <= AMT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    rwsd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_day             (i_day),
        .i_amount_cents    (i_amount_cents),
        .i_last_of_account (i_last_of_account),
        .i_threshold       (r_threshold),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_pop         (cmd_pop)
    );

    rwsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_span_days   (r_span_days),
        .i_threshold   (r_threshold),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (result)
    );

    assign o_flagged        = result.flagged;
    assign o_flag_sum       = result.flag_sum;
    assign o_window_count   = result.window_count;
    assign o_flag_start_day = result.flag_start_day;
    assign o_truncated      = result.truncated;

endmodule

### src/rwsd_front.sv
// Front end: accepts transfers, tags amounts at or above the threshold, two-entry command queue
module rwsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [rwsd_pkg::DAY_W-1:0]    i_day,
    input  logic [rwsd_pkg::AMT_W-1:0]    i_amount_cents,
    input  logic                          i_last_of_account,
    input  logic [rwsd_pkg::AMT_W-1:0]    i_threshold,
    output logic                          o_cmd_valid,
    output rwsd_pkg::t_cmd                o_cmd,
    input  logic                          i_cmd_pop
);
    import rwsd_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rptr];
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wptr] <= '{day:    i_day,
                               amount: i_amount_cents,
                               last:   i_last_of_account,
                               over:   (i_amount_cents >= i_threshold)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/rwsd_back.sv
// Back end: window queue memory, running sums, window evaluation and result register
module rwsd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  rwsd_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic [rwsd_pkg::WDAYS_W-1:0]  i_span_days,
    input  logic [rwsd_pkg::AMT_W-1:0]    i_threshold,
    output logic                          o_valid,
    input  logic                          i_ready,
    output rwsd_pkg::t_result             o_result
);
    import rwsd_pkg::*;

    logic [DAY_W-1:0] r_mem_day [Q_DEPTH];
    logic [AMT_W-1:0] r_mem_amt [Q_DEPTH];

    t_state           r_state, n_state;
    logic [Q_AW-1:0]  r_head, n_head;
    logic [Q_FW-1:0]  r_fill;
    logic [Q_FW-1:0]  r_over;
    logic [SUM_W-1:0] r_sum;
    logic             r_found;
    logic [SUM_W-1:0] r_fsum;
    logic [Q_FW-1:0]  r_fcnt;
    logic [DAY_W-1:0] r_fstart;
    logic             r_cut;
    logic             r_cut_pend;
    logic [DAY_W-1:0] r_hd_day;
    logic [AMT_W-1:0] r_hd_amt;
    logic             r_out_valid;
    t_result          r_out;

    logic [WDAYS_W-1:0] eff_len;
    logic [DAY_W-1:0]   day_gap;
    logic               complete, full, out_free;
    logic [Q_FW:0]      tail_sum;
    logic [Q_AW-1:0]    tail;
    logic [Q_AW-1:0]    head_inc;
    logic               do_pop, do_push, set_cut, do_finish;

    assign eff_len  = (i_span_days == '0) ? WDAYS_W'(1) : i_span_days;
    assign day_gap  = i_cmd.day - r_hd_day;
    assign complete = (r_fill != '0) && (i_cmd.day >= r_hd_day)
                      && (day_gap >= DAY_W'(eff_len));
    assign full     = (r_fill == Q_FW'(Q_DEPTH));
    assign out_free = !r_out_valid || i_ready;

    assign tail_sum = (Q_FW + 1)'(r_head) + (Q_FW + 1)'(r_fill);
    assign tail     = (tail_sum >= (Q_FW + 1)'(Q_DEPTH))
                      ? Q_AW'(tail_sum - (Q_FW + 1)'(Q_DEPTH)) : Q_AW'(tail_sum);
    assign head_inc = (r_head == Q_AW'(Q_DEPTH - 1)) ? '0 : r_head + Q_AW'(1);

    always_comb begin
        n_state   = r_state;
        do_pop    = 1'b0;
        do_push   = 1'b0;
        set_cut   = 1'b0;
        do_finish = 1'b0;
        o_cmd_pop = 1'b0;
        unique case (r_state)
            ST_RUN: begin
                if (i_cmd_valid) begin
                    // after an overflow cut, push without rechecking the new head
                    if (complete && !r_cut_pend) begin
                        do_pop = 1'b1;
                    end else if (full) begin
                        // overflow: evaluate the oldest window as it stands
                        do_pop  = 1'b1;
                        set_cut = 1'b1;
                    end else begin
                        do_push = 1'b1;
                        if (i_cmd.last) begin
                            n_state = ST_DRAIN;
                        end else begin
                            o_cmd_pop = 1'b1;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (r_fill != '0) begin
                    do_pop = 1'b1;
                end else if (out_free) begin
                    do_finish = 1'b1;
                    o_cmd_pop = 1'b1;
                    n_state   = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // Read ahead at the next head so head data is ready every cycle
    always_comb begin
        if (do_finish) begin
            n_head = '0;
        end else if (do_pop) begin
            n_head = head_inc;
        end else begin
            n_head = r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem_day[tail] <= i_cmd.day;
            r_mem_amt[tail] <= i_cmd.amount;
        end
        if (do_push && (tail == n_head)) begin
            r_hd_day <= i_cmd.day;
            r_hd_amt <= i_cmd.amount;
        end else begin
            r_hd_day <= r_mem_day[n_head];
            r_hd_amt <= r_mem_amt[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_head      <= '0;
            r_fill      <= '0;
            r_over      <= '0;
            r_sum       <= '0;
            r_found     <= 1'b0;
            r_fsum      <= '0;
            r_fcnt      <= '0;
            r_fstart    <= '0;
            r_cut       <= 1'b0;
            r_cut_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_cut_pend <= set_cut;
            if (do_pop) begin
                if (!r_found && (r_over == '0) && (r_sum > SUM_W'(i_threshold))) begin
                    r_found  <= 1'b1;
                    r_fsum   <= r_sum;
                    r_fcnt   <= r_fill;
                    r_fstart <= r_hd_day;
                end
                r_sum  <= r_sum - SUM_W'(r_hd_amt);
                r_fill <= r_fill - Q_FW'(1);
                if ((r_hd_amt >= i_threshold) && (r_over != '0)) begin
                    r_over <= r_over - Q_FW'(1);
                end
                if (set_cut) begin
                    r_cut <= 1'b1;
                end
            end
            if (do_push) begin
                r_sum  <= r_sum + SUM_W'(i_cmd.amount);
                r_fill <= r_fill + Q_FW'(1);
                if (i_cmd.over) begin
                    r_over <= r_over + Q_FW'(1);
                end
            end
            if (do_finish) begin
                r_out_valid <= 1'b1;
                r_fill      <= '0;
                r_over      <= '0;
                r_sum       <= '0;
                r_found     <= 1'b0;
                r_fsum      <= '0;
                r_fcnt      <= '0;
                r_fstart    <= '0;
                r_cut       <= 1'b0;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_finish) begin
            r_out.flagged        <= r_found;
            r_out.flag_sum       <= r_found ? sat_sum(r_fsum) : '0;
            r_out.window_count   <= r_found ? WCNT_W'(r_fcnt) : '0;
            r_out.flag_start_day <= r_found ? r_fstart : '0;
            r_out.truncated      <= r_cut;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`include "rolling_window_structuring_detector_assert.svh"

    `RWSD_ASSERT_NEVER(a_fill_bound, r_fill > Q_FW'(Q_DEPTH), "queue fill above depth")
    `RWSD_ASSERT_NEVER(a_over_bound, r_over > r_fill, "over count above fill")
    `RWSD_ASSERT_IMPLY(a_pop_nonempty, do_pop, r_fill != '0, "pop from empty queue")
    `RWSD_ASSERT_IMPLY(a_drain_holds_cmd, r_state == ST_DRAIN, i_cmd_valid, "drain lost last cmd")
    `RWSD_ASSERT_NEXT(a_finish_out, do_finish, r_out_valid && (r_fill == '0), "finish w/o result")

endmodule

### tb/rolling_window_structuring_detector_tb.sv
// Self-checking testbench for the rolling window structuring detector: queued transactions, predicted account reports
module rolling_window_structuring_detector_tb;
    import rwsd_pkg::*;

    localparam int          DEPTH       = Q_DEPTH;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          SETTLE      = 200;
    localparam int          LONG_HOLD   = 800;
    localparam logic [63:0] SUM_MAX     = 64'h3FFF_FFFF_FFFF;

    typedef struct {
        bit [DAY_W-1:0] day;
        bit [AMT_W-1:0] amount;
        bit             last;
    } t_txn;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [DAY_W-1:0]      i_day = '0;
    logic [AMT_W-1:0]      i_amount_cents = '0;
    logic                  i_last_of_account = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_flagged;
    logic [WSUM_W-1:0]     o_flag_sum;
    logic [WCNT_W-1:0]     o_window_count;
    logic [DAY_W-1:0]      o_flag_start_day;
    logic                  o_truncated;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rolling_window_structuring_detector dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_day              (i_day),
        .i_amount_cents     (i_amount_cents),
        .i_last_of_account  (i_last_of_account),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_flagged          (o_flagged),
        .o_flag_sum         (o_flag_sum),
        .o_window_count     (o_window_count),
        .o_flag_start_day   (o_flag_start_day),
        .o_truncated        (o_truncated),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    // Register shadows
    bit [WDAYS_W-1:0] wdays_reg = SPAN_DAYS_RST;
    bit [AMT_W-1:0]   thr_reg   = THRESHOLD_RST;

    // Open windows and scan state of the current account
    bit [DAY_W-1:0] win_day [DEPTH];
    bit [AMT_W-1:0] win_amt [DEPTH];
    int unsigned    win_head = 0;
    int unsigned    win_fill = 0;
    int unsigned    over_cnt = 0;
    bit [63:0]      run_sum = '0;
    bit             hit_flag = 1'b0;
    bit [63:0]      hit_sum = '0;
    int unsigned    hit_cnt = 0;
    bit [DAY_W-1:0] hit_start = '0;
    bit             cut_flag = 1'b0;

    t_txn    pending_txns[$];
    t_result expected_reports[$];
    t_txn    next_txn;

    bit send_busy = 1'b0;
    bit gap_on = 1'b0;
    bit hold_req = 1'b0;
    int send_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int items_queued = 0;
    int items_accepted = 0;
    int reports_seen = 0;
    int flagged_seen = 0;
    int cut_seen = 0;
    int settings_used = 1;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gap_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Evaluate the window opened by the oldest open transaction, then drop it
    task automatic retire_oldest();
        if (win_fill == 0) return;
        if (!hit_flag && over_cnt == 0 && run_sum > 64'(thr_reg)) begin
            hit_flag  = 1'b1;
            hit_sum   = run_sum;
            hit_cnt   = win_fill;
            hit_start = win_day[win_head];
        end
        run_sum = run_sum - 64'(win_amt[win_head]);
        if (win_amt[win_head] >= thr_reg && over_cnt > 0) over_cnt--;
        win_fill--;
        win_head = (win_head + 1) % DEPTH;
    endtask

    task automatic predict_report(input logic [DAY_W-1:0] day, input logic [AMT_W-1:0] amt,
                                  input logic last);
        int unsigned span;
        int unsigned tail;
        t_result     rep;
        span = (wdays_reg == 0) ? 1 : 32'(wdays_reg);
        while (win_fill > 0 && day >= win_day[win_head] &&
               (32'(day) - 32'(win_day[win_head])) >= span)
            retire_oldest();
        if (win_fill >= DEPTH) begin
            retire_oldest();
            cut_flag = 1'b1;
        end
        tail = (win_head + win_fill) % DEPTH;
        win_day[tail] = day;
        win_amt[tail] = amt;
        win_fill++;
        run_sum = run_sum + 64'(amt);
        if (amt >= thr_reg) over_cnt++;
        if (last) begin
            while (win_fill > 0) retire_oldest();
            rep.flagged        = hit_flag;
            rep.flag_sum       = !hit_flag ? '0 : (hit_sum > SUM_MAX) ? '1 : hit_sum[WSUM_W-1:0];
            rep.window_count   = hit_flag ? hit_cnt[WCNT_W-1:0] : '0;
            rep.flag_start_day = hit_flag ? hit_start : '0;
            rep.truncated      = cut_flag;
            expected_reports.insert(expected_reports.size(), rep);
            win_head = 0;
            win_fill = 0;
            over_cnt = 0;
            run_sum  = '0;
            hit_flag = 1'b0;
            hit_sum  = '0;
            hit_cnt  = 0;
            hit_start = '0;
            cut_flag = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Sender: pick the next gap as each transaction is driven, and hold it until transfer
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!send_busy) begin
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_txns.size() > 0) begin
                next_txn = pending_txns.pop_front();
                i_day             <= next_txn.day;
                i_amount_cents    <= next_txn.amount;
                i_last_of_account <= next_txn.last;
                i_valid           <= 1'b1;
                send_busy = 1'b1;
                send_gap  = pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
            i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            rx_gap = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && i_valid && o_ready) begin
            predict_report(i_day, i_amount_cents, i_last_of_account);
            send_busy = 1'b0;
            items_accepted++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none expected, actual flagged %0b sum %0h", $time,
                         o_flagged, o_flag_sum);
                err_cnt++;
            end else begin
                want = expected_reports.pop_front();
                check_field("flagged", 64'(want.flagged), 64'(o_flagged));
                check_field("flag_sum", 64'(want.flag_sum), 64'(o_flag_sum));
                check_field("window_count", 64'(want.window_count), 64'(o_window_count));
                check_field("flag_start_day", 64'(want.flag_start_day),
                            64'(o_flag_start_day));
                check_field("truncated", 64'(want.truncated), 64'(o_truncated));
                reports_seen++;
                if (want.flagged) flagged_seen++;
                if (want.truncated) cut_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d reports still expected", $time, expected_reports.size());
            $display("[rolling_window_structuring_detector] ERROR");
            $finish;
        end
    end

    function automatic void add_txn(input bit [DAY_W-1:0] day, input bit [AMT_W-1:0] amt,
                                    input bit last);
        t_txn t;
        t.day    = day;
        t.amount = amt;
        t.last   = last;
        pending_txns.insert(pending_txns.size(), t);
        items_queued++;
    endfunction

    // Queue one account: mostly ordered days, sometimes a backward jump or a stray day
    function automatic int queue_account();
        int          len;
        int          r;
        int          bad_at;
        int unsigned span;
        bit          dense;
        bit [DAY_W-1:0] d;
        bit [63:0]   a;
        span  = (wdays_reg == 0) ? 1 : 32'(wdays_reg);
        dense = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            len   = $urandom_range(65, 90);
            dense = 1'b1;
        end else if (r < 20) begin
            len = $urandom_range(13, 40);
        end else begin
            len = $urandom_range(1, 12);
        end
        bad_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : -1;
        d = DAY_W'($urandom);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (k > 0 && !dense && r >= 40) begin
                if (r < 85) d = d + DAY_W'($urandom_range(1, span));
                else d = d + DAY_W'($urandom_range(span, 3 * span));
            end
            if (k == bad_at) d = d - DAY_W'($urandom_range(1, 2 * span));
            if ($urandom_range(0, 99) < 3) d = DAY_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 8) a = {$urandom, $urandom};
            else if (r < 18) a = 64'(thr_reg) + 64'($urandom_range(0, 1000));
            else a = (64'(thr_reg) * 64'($urandom_range(20, 60))) / 100;
            add_txn(d, a[AMT_W-1:0], k == len - 1);
        end
        return len;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SPAN_DAYS) wdays_reg = val[WDAYS_W-1:0];
        else thr_reg = val[AMT_W-1:0];
        settings_used++;
    endtask

    // Wait for every transfer and report, then let the back end go quiet
    task automatic drain_and_settle();
        while (pending_txns.size() > 0 || send_busy || expected_reports.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_phase(input int wd, input logic [AMT_W-1:0] th, input int n_items,
                             input bit gaps, input bit hold);
        int added;
        write_reg(CFG_SPAN_DAYS, CFG_DATA_W'(wd));
        write_reg(CFG_THRESHOLD, th);
        gap_on = gaps;
        @(posedge i_clk);
        if (hold) hold_req = 1'b1;
        added = 0;
        while (added < n_items) added += queue_account();
        drain_and_settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_on = 1'b1;

        // Reset values: window of 3 days, threshold 1000000
        add_txn(24'd10, 40'd400000, 1'b0);
        add_txn(24'd11, 40'd400000, 1'b0);
        add_txn(24'd12, 40'd400000, 1'b1);
        // one amount at the threshold blocks the window
        add_txn(24'd20, 40'd1000000, 1'b0);
        add_txn(24'd21, 40'd500000, 1'b1);
        // sum equal to the threshold is not enough
        add_txn(24'd30, 40'd500000, 1'b0);
        add_txn(24'd30, 40'd500000, 1'b1);
        // a later day closes the first window on its own
        add_txn(24'd100, 40'd600000, 1'b0);
        add_txn(24'd103, 40'd600000, 1'b0);
        add_txn(24'd104, 40'd600000, 1'b1);
        // day going backwards closes nothing
        add_txn(24'd200, 40'd1, 1'b0);
        add_txn(24'd150, 40'd999999, 1'b0);
        add_txn(24'd150, 40'd5, 1'b1);
        // field extremes
        add_txn(24'd0, 40'd0, 1'b0);
        add_txn(24'hFFFFFF, 40'hFF_FFFF_FFFF, 1'b1);
        add_txn(24'd7, 40'd0, 1'b1);
        drain_and_settle();

        // zero threshold and zero window length
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_SPAN_DAYS, '0);
        add_txn(24'd5, 40'd0, 1'b0);
        add_txn(24'd5, 40'd0, 1'b0);
        add_txn(24'd6, 40'd0, 1'b1);
        drain_and_settle();

        // largest threshold and window: sum runs past 40 bits
        write_reg(CFG_THRESHOLD, 40'hFF_FFFF_FFFF);
        write_reg(CFG_SPAN_DAYS, 40'hFFFF);
        add_txn(24'd1000, 40'hFF_FFFF_FFFE, 1'b0);
        add_txn(24'd1000, 40'hFF_FFFF_FFFE, 1'b0);
        add_txn(24'd1001, 40'hFF_FFFF_FFFE, 1'b1);
        drain_and_settle();

        run_phase(3, 40'd1000000, 140, 1'b1, 1'b1);
        run_phase(1, 40'd250000, 130, 1'b0, 1'b0);
        run_phase(0, 40'd5000, 110, 1'b1, 1'b0);
        run_phase(65535, 40'd1000000, 130, 1'b1, 1'b0);
        run_phase(7, 40'd0, 90, 1'b1, 1'b0);
        run_phase(30, 40'hFF_FFFF_FFFF, 110, 1'b1, 1'b0);
        run_phase($urandom_range(1, 20), {$urandom, $urandom}, 130, 1'b1, 1'b0);
        run_phase(12, 40'd3000000, 90, 1'b0, 1'b0);

        $display("Covered %0d transactions over %0d register settings, including reset values",
                 items_accepted, settings_used);
        $display("Scored %0d account reports: %0d flagged, %0d truncated by queue overflow",
                 reports_seen, flagged_seen, cut_seen);
        if (err_cnt == 0) begin
            $display("[rolling_window_structuring_detector] OK");
        end else begin
            $display("[rolling_window_structuring_detector] ERROR");
        end
        $finish;
    end

endmodule
